/* sv/crkd_pkg.sv */
`default_nettype none

package crkd_pkg;

    // field and register widths, sizes and queue depth
    localparam int SEG_W            = 6;
    localparam int CFG_W            = 6;
    localparam int BITMAP_BITS      = 64;
    localparam int NUM_SEGMENTS_DEF = 64;
    localparam int QUEUE_DEPTH      = 2;
    localparam int APB_ADDR_W       = 4;
    localparam int APB_DATA_W       = 32;

    // operation codes
    localparam logic OP_PAIR = 1'b0;
    localparam logic OP_EVAL = 1'b1;

    // register indexes (paddr[3:2])
    localparam logic [1:0] REG_MIN_PAIR_DIST = 2'd0;
    localparam logic [1:0] REG_MAX_PAIR_DIST = 2'd1;
    localparam logic [1:0] REG_MAX_RUN_GAP   = 2'd2;

    // register reset values
    localparam logic [CFG_W-1:0] RST_MIN_PAIR_DIST = 6'd3;
    localparam logic [CFG_W-1:0] RST_MAX_PAIR_DIST = 6'd15;
    localparam logic [CFG_W-1:0] RST_MAX_RUN_GAP   = 6'd7;

    typedef struct packed {
        logic             operation;
        logic [SEG_W-1:0] segment_a;
        logic [SEG_W-1:0] segment_b;
    } t_item;

    typedef struct packed {
        logic             knot_found;
        logic [SEG_W-1:0] knot_start;
        logic [SEG_W-1:0] knot_end;
    } t_result;

    typedef struct packed {
        logic [CFG_W-1:0] min_pair_distance;
        logic [CFG_W-1:0] max_pair_distance;
        logic [CFG_W-1:0] max_run_gap;
    } t_cfg;

    // classified item handed from front to back
    typedef struct packed {
        logic             is_eval;
        logic             keep;
        logic [SEG_W-1:0] seg_a;
        logic [SEG_W-1:0] seg_b;
    } t_cmd;

    typedef enum logic {
        ST_IDLE,
        ST_SCAN
    } t_state;

endpackage

`default_nettype wire

/* sv/collision_run_knot_detector_unit.sv */
`default_nettype none

// Collision run knot detector.
// Input: an item is transferred at a rising edge with start high and busy low.
// A frame is a series of pair items (operation 0) followed by one evaluate item
// (operation 1). Pairs whose index distance lies strictly between the two APB
// limits mark both segments in a bitmap of min(NUM_SEGMENTS, 64) bits.
// Output: one result per evaluate, shown for exactly one cycle with
// o_result_valid high; pair items give no result. The receiver cannot stall.
// Result: an evaluate with the detector disarmed is answered from idle with no
// scan; otherwise the bitmap scan walks one segment a cycle, stops at the first
// knot or at the last segment, and then registers the result.
// Throughput: pair items flow at one per cycle through a two-entry queue; while
// the scan runs, the queue fills and busy rises until the back end is free.
// After a knot is found the detector disarms until reset.
// Reset (synchronous, i_rst_n low): registers go to 3 / 15 / 7, the bitmap
// clears, the detector arms and the queue empties. No clearing pass is needed.
// Registers: byte addresses 0, 4, 8 on the APB port; pready is always high.

module collision_run_knot_detector_unit #(
    parameter int NUM_SEGMENTS = crkd_pkg::NUM_SEGMENTS_DEF
) (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    input  wire logic                            start,
    output logic                                 busy,
    input  crkd_pkg::t_item                      i_item,
    output logic                                 o_result_valid,
    output crkd_pkg::t_result                    o_result,
    input  wire logic                            psel,
    input  wire logic                            penable,
    input  wire logic                            pwrite,
    input  wire logic [crkd_pkg::APB_ADDR_W-1:0] paddr,
    input  wire logic [crkd_pkg::APB_DATA_W-1:0] pwdata,
    output logic      [crkd_pkg::APB_DATA_W-1:0] prdata,
    output logic                                 pready
);
    import crkd_pkg::*;

    t_cfg cfg;
    t_cmd front_cmd;
    t_cmd queue_cmd;
    logic queue_valid;
    logic queue_full;
    logic pop;
    logic push;

    assign busy = queue_full;
    assign push = start & ~busy;

    // configuration registers
    crkd_regs u_regs (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (cfg)
    );

    // classify incoming items
    crkd_front #(
        .NUM_SEGMENTS (NUM_SEGMENTS)
    ) u_front (
        .i_item (i_item),
        .i_cfg  (cfg),
        .o_cmd  (front_cmd)
    );

    // decoupling queue
    crkd_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_cmd   (front_cmd),
        .i_pop   (pop),
        .o_cmd   (queue_cmd),
        .o_valid (queue_valid),
        .o_full  (queue_full)
    );

    // bitmap and run scan
    crkd_back #(
        .NUM_SEGMENTS (NUM_SEGMENTS)
    ) u_back (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cmd          (queue_cmd),
        .i_cmd_valid    (queue_valid),
        .i_cfg          (cfg),
        .o_pop          (pop),
        .o_result_valid (o_result_valid),
        .o_result       (o_result)
    );

endmodule

`default_nettype wire

/* sv/crkd_regs.sv */
`default_nettype none

module crkd_regs (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    input  wire logic                           psel,
    input  wire logic                           penable,
    input  wire logic                           pwrite,
    input  wire logic [crkd_pkg::APB_ADDR_W-1:0] paddr,
    input  wire logic [crkd_pkg::APB_DATA_W-1:0] pwdata,
    output logic      [crkd_pkg::APB_DATA_W-1:0] prdata,
    output logic                                pready,
    output crkd_pkg::t_cfg                      o_cfg
);
    import crkd_pkg::*;

    t_cfg       r_cfg;
    logic       wr_en;
    logic [1:0] reg_idx;

    assign pready  = 1'b1;
    assign reg_idx = paddr[3:2];
    assign wr_en   = psel & penable & pwrite & pready;

    // register file, written on the access phase of a transfer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.min_pair_distance <= RST_MIN_PAIR_DIST;
            r_cfg.max_pair_distance <= RST_MAX_PAIR_DIST;
            r_cfg.max_run_gap       <= RST_MAX_RUN_GAP;
        end else if (wr_en) begin
            unique case (reg_idx)
                REG_MIN_PAIR_DIST: r_cfg.min_pair_distance <= pwdata[CFG_W-1:0];
                REG_MAX_PAIR_DIST: r_cfg.max_pair_distance <= pwdata[CFG_W-1:0];
                REG_MAX_RUN_GAP:   r_cfg.max_run_gap       <= pwdata[CFG_W-1:0];
                default: ;
            endcase
        end
    end

    // read back
    always_comb begin
        unique case (reg_idx)
            REG_MIN_PAIR_DIST: prdata = APB_DATA_W'(r_cfg.min_pair_distance);
            REG_MAX_PAIR_DIST: prdata = APB_DATA_W'(r_cfg.max_pair_distance);
            REG_MAX_RUN_GAP:   prdata = APB_DATA_W'(r_cfg.max_run_gap);
            default:           prdata = '0;
        endcase
    end

    assign o_cfg = r_cfg;

endmodule

`default_nettype wire

/* sv/crkd_front.sv */
`default_nettype none

module crkd_front #(
    parameter int NUM_SEGMENTS = crkd_pkg::NUM_SEGMENTS_DEF
) (
    input  crkd_pkg::t_item i_item,
    input  crkd_pkg::t_cfg  i_cfg,
    output crkd_pkg::t_cmd  o_cmd
);
    import crkd_pkg::*;

    localparam int MAP_BITS = (NUM_SEGMENTS < BITMAP_BITS) ? NUM_SEGMENTS : BITMAP_BITS;
    localparam logic [SEG_W:0] LIM_V = (SEG_W+1)'(MAP_BITS);

    logic [SEG_W-1:0] pair_dist;
    logic             a_ok;
    logic             b_ok;

    // index distance and range checks of a pair
    always_comb begin
        if (i_item.segment_a > i_item.segment_b) begin
            pair_dist = i_item.segment_a - i_item.segment_b;
        end else begin
            pair_dist = i_item.segment_b - i_item.segment_a;
        end
        a_ok = {1'b0, i_item.segment_a} < LIM_V;
        b_ok = {1'b0, i_item.segment_b} < LIM_V;
    end

    assign o_cmd.is_eval = (i_item.operation == OP_EVAL);
    assign o_cmd.keep    = a_ok & b_ok &
                           (pair_dist > i_cfg.min_pair_distance) &
                           (pair_dist < i_cfg.max_pair_distance);
    assign o_cmd.seg_a   = i_item.segment_a;
    assign o_cmd.seg_b   = i_item.segment_b;

endmodule

`default_nettype wire

/* sv/crkd_queue.sv */
`default_nettype none

module crkd_queue (
    input  wire logic      i_clk,
    input  wire logic      i_rst_n,
    input  wire logic      i_push,
    input  crkd_pkg::t_cmd i_cmd,
    input  wire logic      i_pop,
    output crkd_pkg::t_cmd o_cmd,
    output logic           o_valid,
    output logic           o_full
);
    import crkd_pkg::*;

    localparam int PTR_W = $clog2(QUEUE_DEPTH);
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

    t_cmd             r_entry [QUEUE_DEPTH];
    logic [PTR_W-1:0] r_wr_ptr;
    logic [PTR_W-1:0] r_rd_ptr;
    logic [CNT_W-1:0] r_count;
    logic             do_push;
    logic             do_pop;

    assign o_valid = (r_count != '0);
    assign o_full  = (r_count == CNT_W'(QUEUE_DEPTH));
    assign do_push = i_push & ~o_full;
    assign do_pop  = i_pop & o_valid;
    assign o_cmd   = r_entry[r_rd_ptr];

    // storage
    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_entry[r_wr_ptr] <= i_cmd;
        end
    end

    // pointers and fill level
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (do_push) begin
                r_wr_ptr <= r_wr_ptr + PTR_W'(1);
            end
            if (do_pop) begin
                r_rd_ptr <= r_rd_ptr + PTR_W'(1);
            end
            if (do_push && !do_pop) begin
                r_count <= r_count + CNT_W'(1);
            end else if (do_pop && !do_push) begin
                r_count <= r_count - CNT_W'(1);
            end
        end
    end

endmodule

`default_nettype wire

/* sv/crkd_back.sv */
`default_nettype none

module crkd_back #(
    parameter int NUM_SEGMENTS = crkd_pkg::NUM_SEGMENTS_DEF
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  crkd_pkg::t_cmd   i_cmd,
    input  wire logic        i_cmd_valid,
    input  crkd_pkg::t_cfg   i_cfg,
    output logic             o_pop,
    output logic             o_result_valid,
    output crkd_pkg::t_result o_result
);
    import crkd_pkg::*;

    localparam int MAP_BITS = (NUM_SEGMENTS < BITMAP_BITS) ? NUM_SEGMENTS : BITMAP_BITS;
    localparam int IDX_W    = $clog2(MAP_BITS);

    t_state              r_state,     n_state;
    logic [MAP_BITS-1:0] r_map,       n_map;
    logic                r_armed,     n_armed;
    logic [IDX_W-1:0]    r_idx,       n_idx;
    logic                r_in_run,    n_in_run;
    logic [IDX_W-1:0]    r_cur_s,     n_cur_s;
    logic                r_have_prev, n_have_prev;
    logic [IDX_W-1:0]    r_prev_s,    n_prev_s;
    logic [IDX_W-1:0]    r_prev_e,    n_prev_e;
    logic                r_res_valid, n_res_valid;
    t_result             r_result,    n_result;

    logic             bit_now;
    logic             run_end;
    logic             last;
    logic             hit;
    logic [IDX_W-1:0] run_s;
    logic [IDX_W-1:0] span_prev;
    logic [IDX_W-1:0] span_cur;
    logic [IDX_W-1:0] gap;

    // scan datapath: the bitmap shifts down one bit a cycle, bit 0 is segment r_idx
    always_comb begin
        bit_now   = r_map[0];
        run_end   = r_map[0] & ~r_map[1];
        last      = (r_idx == IDX_W'(MAP_BITS - 1));
        run_s     = r_in_run ? r_cur_s : r_idx;
        span_prev = r_prev_e - r_prev_s;
        span_cur  = r_idx - run_s;
        gap       = run_s - r_prev_e;
        hit       = run_end & r_have_prev &
                    (span_prev > IDX_W'(1)) & (span_cur > IDX_W'(1)) &
                    (SEG_W'(gap) < i_cfg.max_run_gap);
    end

    // state register and scan registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_map       <= '0;
            r_armed     <= 1'b1;
            r_res_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_map       <= n_map;
            r_armed     <= n_armed;
            r_res_valid <= n_res_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_idx       <= n_idx;
        r_in_run    <= n_in_run;
        r_cur_s     <= n_cur_s;
        r_have_prev <= n_have_prev;
        r_prev_s    <= n_prev_s;
        r_prev_e    <= n_prev_e;
        r_result    <= n_result;
    end

    // next state: mark pairs, start a scan or answer a disarmed evaluate, walk the runs
    always_comb begin
        n_state     = r_state;
        n_map       = r_map;
        n_armed     = r_armed;
        n_idx       = r_idx;
        n_in_run    = r_in_run;
        n_cur_s     = r_cur_s;
        n_have_prev = r_have_prev;
        n_prev_s    = r_prev_s;
        n_prev_e    = r_prev_e;
        n_res_valid = 1'b0;
        n_result    = r_result;
        o_pop       = 1'b0;

        unique case (r_state)
            ST_IDLE: begin
                if (i_cmd_valid) begin
                    o_pop = 1'b1;
                    if (!i_cmd.is_eval) begin
                        if (i_cmd.keep && r_armed) begin
                            n_map[i_cmd.seg_a[IDX_W-1:0]] = 1'b1;
                            n_map[i_cmd.seg_b[IDX_W-1:0]] = 1'b1;
                        end
                    end else if (r_armed) begin
                        n_state     = ST_SCAN;
                        n_idx       = '0;
                        n_in_run    = 1'b0;
                        n_have_prev = 1'b0;
                    end else begin
                        n_res_valid = 1'b1;
                        n_result    = '0;
                        n_map       = '0;
                    end
                end
            end
            ST_SCAN: begin
                n_map = r_map >> 1;
                n_idx = r_idx + IDX_W'(1);
                if (bit_now) begin
                    n_in_run = 1'b1;
                    n_cur_s  = run_s;
                end
                if (run_end) begin
                    n_in_run    = 1'b0;
                    n_have_prev = 1'b1;
                    n_prev_s    = run_s;
                    n_prev_e    = r_idx;
                end
                if (hit) begin
                    n_state             = ST_IDLE;
                    n_map               = '0;
                    n_armed             = 1'b0;
                    n_res_valid         = 1'b1;
                    n_result.knot_found = 1'b1;
                    n_result.knot_start = SEG_W'(r_prev_s);
                    n_result.knot_end   = SEG_W'(r_idx);
                end else if (last) begin
                    n_state     = ST_IDLE;
                    n_map       = '0;
                    n_res_valid = 1'b1;
                    n_result    = '0;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    assign o_result_valid = r_res_valid;
    assign o_result       = r_result;

endmodule

`default_nettype wire

/* sv/crkd_checker.sv */
`default_nettype none

module crkd_checker (
    input wire logic        i_clk,
    input wire logic        i_rst_n,
    input wire logic        o_result_valid,
    input crkd_pkg::t_result o_result
);
    import crkd_pkg::*;

    logic r_seen_knot;

    // remembers that a knot has been reported since reset
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_seen_knot <= 1'b0;
        end else if (o_result_valid && o_result.knot_found) begin
            r_seen_knot <= 1'b1;
        end
    end

    // no stale result strobe straight after reset
    a_reset_quiet: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_result_valid)
        else $error("result strobe right after reset");

    // a frame without a knot reports zero positions
    a_no_knot_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_result_valid && !o_result.knot_found) |->
        (o_result.knot_start == '0 && o_result.knot_end == '0))
        else $error("non-zero positions without a knot");

    // a reported knot ends above its start
    a_knot_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_result_valid && o_result.knot_found) |->
        (o_result.knot_end > o_result.knot_start))
        else $error("knot end not above knot start");

    // once disarmed, no further knot is reported
    a_one_knot: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_result_valid && r_seen_knot) |-> !o_result.knot_found)
        else $error("second knot reported after disarm");

endmodule

bind collision_run_knot_detector_unit crkd_checker u_checker (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .o_result_valid (o_result_valid),
    .o_result       (o_result)
);

`default_nettype wire
